>>> design/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked through reset.
`define ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/dbed_pkg.sv
// Package for the button debouncer: payload structs, codes, widths and helpers.
// No dependencies; used by every module of the block.
package dbed_pkg;

  // Channel count and derived index width
  localparam int CHANNELS  = 8;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_FLD_W  = 3;
  localparam int CH_CMP_W  = 7;
  localparam logic [CH_CMP_W-1:0] CH_LIMIT = CH_CMP_W'(CHANNELS);

  // Counter and threshold widths
  localparam int CNT_W = 11;
  localparam int THR_W = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_CLEAR = 2'd2;
  localparam logic [THR_W-1:0] STARTUP_RST     = 10'd10;
  localparam logic [THR_W-1:0] DEBOUNCE_RST    = 10'd5;
  localparam logic [THR_W-1:0] EVENT_CLEAR_RST = 10'd100;

  typedef enum logic [1:0] {
    OP_LATCH = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2
  } op_e_t;

  typedef enum logic [1:0] {
    EV_IDLE = 2'd0,
    EV_RISE = 2'd1,
    EV_FALL = 2'd2,
    EV_INIT = 2'd3
  } ev_e_t;

  typedef enum logic [1:0] {
    LV_LOW  = 2'd0,
    LV_HIGH = 2'd1,
    LV_INIT = 2'd2
  } lvl_e_t;

  typedef struct packed {
    op_e_t               operation;
    logic [CH_FLD_W-1:0] channel;
    logic                level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [1:0] debounced_state;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0] startup;
    logic [THR_W-1:0] debounce;
    logic [THR_W-1:0] event_clear;
  } cfg_t;

  typedef struct packed {
    logic             raw;
    lvl_e_t           acc;
    logic [CNT_W-1:0] cnt;
    ev_e_t            ev;
    logic [CNT_W-1:0] age;
  } chan_state_t;

  localparam chan_state_t CHAN_RST = '{
    raw: 1'b0, acc: LV_INIT, cnt: '0, ev: EV_INIT, age: '0
  };

  // Saturating increment of a tick counter
  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

>>> design/debounced_button_event_detector.sv
// Multi-channel button debouncer with rising/falling edge events.
// Depends on dbed_pkg and dbed_chan_update.
//
// Usage:
//   in_*  : one item per transfer: operation (latch level, tick, read and
//           clear), channel and raw level.
//   out_* : one result per item: the channel's event and debounced state.
//   cfg_* : register writes (0 start-up ticks, 1 debounce ticks, 2 event
//           clear ticks), always ready; write only while no item is in flight.
// Path: an item sits in the input register, then the channel update loads
//   the result register from it as the item moves on.
// Throughput: one item per cycle while not stalled, also for back-to-back
//   items on the same channel, since the channel state is read and written
//   in the same cycle in which the item moves from input to result register.
// Stall: while out_ready is low, the held result stays put and one more item
//   waits in the input register; in_ready drops only when both are full.
// Reset: all channels return to initializing (event 3, state 2), counters
//   clear and the registers take their reset values; no clearing pass.
module debounced_button_event_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dbed_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dbed_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dbed_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dbed_pkg::THR_W-1:0]       cfg_data
);
  import dbed_pkg::*;

  cfg_t                 cfg_r;
  logic                 s1_valid_r;
  in_item_t             s1_item_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;
  chan_state_t          chan_r [CHANNELS];

  logic                 fire;
  logic                 ch_ok;
  logic [CH_IDX_W-1:0]  ch_idx;
  chan_state_t          st_cur;
  chan_state_t          st_nxt;
  out_item_t            res;

  // Handshake
  assign fire      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || fire;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ch_ok  = (CH_CMP_W'(s1_item_r.channel) < CH_LIMIT);
  assign ch_idx = CH_IDX_W'(s1_item_r.channel);
  assign st_cur = chan_r[ch_idx];

  dbed_chan_update u_upd (
    .st     (st_cur),
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.startup     <= STARTUP_RST;
      cfg_r.debounce    <= DEBOUNCE_RST;
      cfg_r.event_clear <= EVENT_CLEAR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STARTUP:     cfg_r.startup     <= cfg_data;
        CFG_DEBOUNCE:    cfg_r.debounce    <= cfg_data;
        CFG_EVENT_CLEAR: cfg_r.event_clear <= cfg_data;
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; out-of-range channel reports zeros
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= ch_ok ? res : '0;
    end
  end

  // Per-channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_r[i] <= CHAN_RST;
      end
    end else if (fire && ch_ok) begin
      chan_r[ch_idx] <= st_nxt;
    end
  end

endmodule

>>> design/dbed_chan_update.sv
// Next-state and result logic for one channel and one operation.
// Depends on dbed_pkg.
module dbed_chan_update (
  input  dbed_pkg::chan_state_t st,
  input  dbed_pkg::in_item_t    item,
  input  dbed_pkg::cfg_t        cfg,
  output dbed_pkg::chan_state_t st_nxt,
  output dbed_pkg::out_item_t   res
);
  import dbed_pkg::*;

  chan_state_t      upd;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] age_inc;

  assign cnt_inc = bump(st.cnt);
  assign age_inc = bump(st.age);

  // Latch / tick update
  always_comb begin
    upd = st;
    unique case (item.operation)
      OP_LATCH: begin
        upd.raw = item.level;
      end
      OP_TICK: begin
        if (st.ev == EV_INIT) begin
          // start-up wait
          if (st.cnt > {1'b0, cfg.startup}) begin
            upd.cnt = '0;
            upd.acc = lvl_e_t'({1'b0, st.raw});
            upd.ev  = EV_IDLE;
          end else begin
            upd.cnt = cnt_inc;
            upd.acc = LV_INIT;
          end
        end else if ({1'b0, st.raw} != st.acc) begin
          // level differs: count toward acceptance
          if (cnt_inc > {1'b0, cfg.debounce}) begin
            upd.ev  = st.raw ? EV_RISE : EV_FALL;
            upd.acc = lvl_e_t'({1'b0, st.raw});
            upd.cnt = '0;
            upd.age = '0;
          end else begin
            upd.cnt = cnt_inc;
          end
        end else begin
          // stable: age a pending edge event
          upd.cnt = '0;
          if (st.ev == EV_RISE || st.ev == EV_FALL) begin
            if (age_inc > {1'b0, cfg.event_clear}) begin
              upd.age = '0;
              upd.ev  = EV_IDLE;
            end else begin
              upd.age = age_inc;
            end
          end
        end
      end
      default: begin
        upd = st;
      end
    endcase
  end

  // Read clears the event after it is reported, except the initializing event
  always_comb begin
    st_nxt = upd;
    if (item.operation == OP_READ && upd.ev != EV_INIT) begin
      st_nxt.ev = EV_IDLE;
    end
    res.event_res       = upd.ev;
    res.debounced_state = upd.acc;
  end

endmodule

>>> design/dbed_checker.sv
// Port-level checker for the button debouncer, bound to the top level.
// Depends on dbed_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dbed_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input dbed_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input dbed_pkg::out_item_t             out_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [dbed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [dbed_pkg::THR_W-1:0]      cfg_data
);
  import dbed_pkg::*;

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // no result right after reset
  `ASSERT_NEXT_RST(a_rst_quiet, !rst_n, !out_valid)

  // initializing state and initializing event always appear together
  `ASSERT_IMPL(a_init_pair, out_valid,
    (out_data.event_res == EV_INIT) == (out_data.debounced_state == LV_INIT))

  // debounced state never shows the unused code
  `ASSERT_IMPL(a_state_code, out_valid, out_data.debounced_state != 2'd3)

endmodule

bind debounced_button_event_detector dbed_checker u_dbed_checker (.*);
